>>> rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int PRIO_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADPRIO = 2'd3
  } status_t;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [PRIO_W-1:0] PRIO_MIN = 3'd1;

endpackage

>>> rtl/core/spq_ram.sv
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/stable_priority_queue.sv
// Stable priority queue: per-level linked lists over a shared entry RAM.
// Enqueue: IDLE, ALLOC when a recycled slot is popped from the free list, then LINK;
// a rejected enqueue finishes in IDLE. Dequeue: IDLE, SCAN (at most PRIORITY_LEVELS
// levels), then DEQ on the registered entry and link RAM reads; empty finishes in IDLE.
// One item at a time; a result blocked at the output waits in a holding register.
// Synchronous reset empties the queue at once; the RAMs are not cleared.
module stable_priority_queue #(
  parameter int CAPACITY        = 64,
  parameter int PRIORITY_LEVELS = 5
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic signed [spq_pkg::DATA_W-1:0]    data,
  input  logic        [spq_pkg::PRIO_W-1:0]    priority_req,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [spq_pkg::DATA_W-1:0]    out_data,
  output logic        [spq_pkg::STAT_W-1:0]    status,
  output logic        [$clog2(CAPACITY+1)-1:0] occupancy
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int DW = spq_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_LINK,
    S_SCAN,
    S_DEQ,
    S_EMIT
  } state_t;

  state_t state;

  logic [CW-1:0]     count;
  logic [CW-1:0]     hwm;
  logic [AW-1:0]     free_head;
  logic [AW-1:0]     head [PRIORITY_LEVELS];
  logic [AW-1:0]     tail [PRIORITY_LEVELS];
  logic [CW-1:0]     lcnt [PRIORITY_LEVELS];
  logic [LW-1:0]     lvl;
  logic [AW-1:0]     slot;
  logic [DW-1:0]     data_r;
  logic [DW-1:0]     res_data;
  spq_pkg::status_t  res_status;

  logic              accept;
  logic              prio_ok;
  logic              is_full;
  logic              free_avail;
  logic              lvl_busy;

  logic              done;
  logic              emit_ok;
  logic [DW-1:0]     d_data;
  spq_pkg::status_t  d_status;
  logic [CW-1:0]     d_occ;

  logic              link_we;
  logic [AW-1:0]     link_waddr;
  logic [AW-1:0]     link_wdata;
  logic              link_re;
  logic [AW-1:0]     link_raddr;
  logic [AW-1:0]     link_rdata;
  logic              data_we;
  logic              data_re;
  logic [DW-1:0]     data_rdata;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign prio_ok    = (priority_req != '0) &&
                      (priority_req <= spq_pkg::PRIO_W'(PRIORITY_LEVELS));
  assign is_full    = (count == CW'(CAPACITY));
  assign free_avail = (hwm != count);
  assign lvl_busy   = (lcnt[lvl] != '0);
  assign emit_ok    = !out_valid || !out_stall;

  // Result of the item finishing this cycle
  always_comb begin
    done     = 1'b0;
    d_data   = '0;
    d_status = spq_pkg::ST_OK;
    d_occ    = count;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == spq_pkg::OP_DEQ) begin
            if (count == '0) begin
              done     = 1'b1;
              d_status = spq_pkg::ST_EMPTY;
            end
          end else if (!prio_ok) begin
            done     = 1'b1;
            d_status = spq_pkg::ST_BADPRIO;
          end else if (is_full) begin
            done     = 1'b1;
            d_status = spq_pkg::ST_FULL;
          end
        end
      end
      S_LINK: begin
        done  = 1'b1;
        d_occ = count + CW'(1);
      end
      S_DEQ: begin
        done   = 1'b1;
        d_data = data_rdata;
        d_occ  = count - CW'(1);
      end
      S_EMIT: begin
        done     = 1'b1;
        d_data   = res_data;
        d_status = res_status;
      end
      default: begin
      end
    endcase
  end

  // RAM port control
  always_comb begin
    link_re    = 1'b0;
    link_raddr = free_head;
    data_re    = 1'b0;
    if (state == S_IDLE && accept && op == spq_pkg::OP_ENQ && prio_ok && !is_full &&
        free_avail) begin
      link_re = 1'b1;
    end else if (state == S_SCAN && lvl_busy) begin
      link_re    = 1'b1;
      link_raddr = head[lvl];
      data_re    = 1'b1;
    end
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot;
    link_wdata = free_head;
    if (state == S_LINK && lvl_busy) begin
      // chain the new entry behind the level's tail
      link_we    = 1'b1;
      link_waddr = tail[lvl];
      link_wdata = slot;
    end else if (state == S_DEQ) begin
      // push the released slot onto the free list
      link_we = 1'b1;
    end
  end

  assign data_we = (state == S_LINK);

  spq_ram #(
    .WIDTH (AW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  spq_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (slot),
    .wdata (data_r),
    .re    (data_re),
    .raddr (link_raddr),
    .rdata (data_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      hwm       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        lcnt[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && !(done && emit_ok)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == spq_pkg::OP_DEQ) begin
              if (count != '0) begin
                lvl   <= '0;
                state <= S_SCAN;
              end
            end else if (prio_ok && !is_full) begin
              lvl    <= LW'(priority_req - spq_pkg::PRIO_MIN);
              data_r <= data;
              if (free_avail) begin
                slot  <= free_head;
                state <= S_ALLOC;
              end else begin
                slot  <= hwm[AW-1:0];
                hwm   <= hwm + CW'(1);
                state <= S_LINK;
              end
            end
          end
        end
        S_ALLOC: begin
          free_head <= link_rdata;
          state     <= S_LINK;
        end
        S_LINK: begin
          if (!lvl_busy) begin
            head[lvl] <= slot;
          end
          tail[lvl] <= slot;
          lcnt[lvl] <= lcnt[lvl] + CW'(1);
          count     <= count + CW'(1);
        end
        S_SCAN: begin
          if (lvl_busy) begin
            slot  <= head[lvl];
            state <= S_DEQ;
          end else begin
            lvl <= lvl + LW'(1);
          end
        end
        S_DEQ: begin
          if (lcnt[lvl] != CW'(1)) begin
            head[lvl] <= link_rdata;
          end
          lcnt[lvl] <= lcnt[lvl] - CW'(1);
          count     <= count - CW'(1);
          free_head <= slot;
        end
        S_EMIT: begin
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Hand the result over, or hold it until the output register frees up
      if (done) begin
        if (emit_ok) begin
          out_valid <= 1'b1;
          out_data  <= d_data;
          status    <= d_status;
          occupancy <= d_occ;
          state     <= S_IDLE;
        end else begin
          res_data   <= d_data;
          res_status <= d_status;
          state      <= S_EMIT;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_hwm_cover: assert property (@(posedge clk) disable iff (rst)
    hwm >= count)
    else $error("more entries held than slots ever allocated");

  a_deq_level: assert property (@(posedge clk) disable iff (rst)
    state == S_DEQ |-> lcnt[lvl] != '0)
    else $error("dequeue from an empty level");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_EMPTY |-> occupancy == '0)
    else $error("empty beat reports entries held");

  a_empty_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && op == spq_pkg::OP_DEQ && count == '0 |=> count == '0)
    else $error("dequeue on empty queue changed the count");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CAP         = 64;
  localparam int PRIO_LEVELS = 5;
  localparam int OCC_W       = $clog2(CAP + 1);
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 12;

  typedef struct {
    logic signed [spq_pkg::DATA_W-1:0] word;
    spq_pkg::status_t                  stat;
    logic [OCC_W-1:0]                  occ;
  } queue_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              op = spq_pkg::OP_ENQ;
  logic signed [spq_pkg::DATA_W-1:0] data = '0;
  logic [spq_pkg::PRIO_W-1:0]        priority_req = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [spq_pkg::DATA_W-1:0] out_data;
  logic [spq_pkg::STAT_W-1:0]        status;
  logic [OCC_W-1:0]                  occupancy;

  // shadow of the queue contents, kept in service order
  logic signed [spq_pkg::DATA_W-1:0] held_word [CAP];
  logic [spq_pkg::PRIO_W-1:0]        held_prio [CAP];
  int                                held_count = 0;

  queue_result_t awaited_results[$];
  int            failures = 0;
  bit            quiet = 1'b0;
  int            stall_run = 0;
  int            dead_cycles = 0;

  stable_priority_queue #(
    .CAPACITY       (CAP),
    .PRIORITY_LEVELS(PRIO_LEVELS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .data        (data),
    .priority_req(priority_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .status      (status),
    .occupancy   (occupancy)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Work out what one item returns and update the shadow queue.
  task automatic model_queue_op(input logic o, input logic signed [spq_pkg::DATA_W-1:0] d,
                                input logic [spq_pkg::PRIO_W-1:0] p);
    queue_result_t r;
    int pos;
    r.word = '0;
    r.stat = spq_pkg::ST_OK;
    if (o == spq_pkg::OP_ENQ) begin
      if (p < spq_pkg::PRIO_MIN || p > PRIO_LEVELS) begin
        r.stat = spq_pkg::ST_BADPRIO;
      end else if (held_count >= CAP) begin
        r.stat = spq_pkg::ST_FULL;
      end else begin
        // land behind every entry of equal or better priority
        pos = held_count;
        while (pos > 0 && held_prio[pos-1] > p) begin
          held_word[pos] = held_word[pos-1];
          held_prio[pos] = held_prio[pos-1];
          pos--;
        end
        held_word[pos] = d;
        held_prio[pos] = p;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.stat = spq_pkg::ST_EMPTY;
    end else begin
      r.word = held_word[0];
      for (int i = 1; i < held_count; i++) begin
        held_word[i-1] = held_word[i];
        held_prio[i-1] = held_prio[i];
      end
      held_count--;
    end
    r.occ = OCC_W'(held_count);
    awaited_results.push_back(r);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic logic signed [spq_pkg::DATA_W-1:0] pick_word();
    unique case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [spq_pkg::PRIO_W-1:0] pick_prio();
    if ($urandom_range(0, 19) == 0) return spq_pkg::PRIO_W'($urandom_range(0, 7));
    return spq_pkg::PRIO_W'($urandom_range(1, PRIO_LEVELS));
  endfunction

  // Drive one beat and hold it until the block takes it.
  task automatic send_item(input logic o, input logic signed [spq_pkg::DATA_W-1:0] d,
                           input logic [spq_pkg::PRIO_W-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    data         <= d;
    priority_req <= p;
    model_queue_op(o, d, p);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  task automatic test_corner_items();
    send_item(spq_pkg::OP_DEQ, 32'sd99, 3'd1);
    send_item(spq_pkg::OP_ENQ, 32'sd5, 3'd0);
    send_item(spq_pkg::OP_ENQ, 32'sd6, 3'd6);
    send_item(spq_pkg::OP_ENQ, 32'sd7, 3'd7);
    send_item(spq_pkg::OP_ENQ, 32'sh8000_0000, 3'd5);
    send_item(spq_pkg::OP_ENQ, 32'sh7FFF_FFFF, 3'd1);
    send_item(spq_pkg::OP_ENQ, 32'sd0, 3'd3);
    send_item(spq_pkg::OP_ENQ, -32'sd1, 3'd3);
    send_item(spq_pkg::OP_ENQ, 32'sd1, 3'd3);
    send_item(spq_pkg::OP_ENQ, 32'sh5A5A_A5A5, 3'd2);
    send_item(spq_pkg::OP_ENQ, 32'sh0F0F_F0F0, 3'd4);
    repeat (7) send_item(spq_pkg::OP_DEQ, $urandom, 3'd7);
    send_item(spq_pkg::OP_DEQ, $urandom, 3'd0);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < CAP; i++) begin
      send_item(spq_pkg::OP_ENQ, pick_word(),
                spq_pkg::PRIO_W'($urandom_range(1, PRIO_LEVELS)));
    end
    send_item(spq_pkg::OP_ENQ, 32'sd42, 3'd1);
    // bad priority wins over full
    send_item(spq_pkg::OP_ENQ, 32'sd43, 3'd0);
    send_item(spq_pkg::OP_ENQ, 32'sd44, 3'd7);
    hold_until_drained();
    for (int i = 0; i <= CAP; i++) begin
      send_item(spq_pkg::OP_DEQ, $urandom, spq_pkg::PRIO_W'($urandom_range(0, 7)));
    end
  endtask

  task automatic test_random_traffic();
    int enq_pct;
    for (int phase = 0; phase < 17; phase++) begin
      unique case (phase % 3)
        0: enq_pct = 80;
        1: enq_pct = 25;
        default: enq_pct = 52;
      endcase
      quiet = (phase % 4 == 3);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 99) < enq_pct) begin
          send_item(spq_pkg::OP_ENQ, pick_word(), pick_prio());
        end else begin
          send_item(spq_pkg::OP_DEQ, $urandom, spq_pkg::PRIO_W'($urandom_range(0, 7)));
        end
      end
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    queue_result_t e;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("unexpected beat: data %0d status %0d occupancy %0d",
                               out_data, status, occupancy));
      end else begin
        e = awaited_results.pop_front();
        if (out_data !== e.word || status !== e.stat || occupancy !== e.occ)
          note_failure($sformatf(
            "mismatch: data exp %0d got %0d, status exp %0d got %0d, occupancy exp %0d got %0d",
            e.word, out_data, e.stat, status, e.occ, occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_corner_items();
    test_full_store();
    test_random_traffic();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
